// ===== src/pid_pkg.sv =====
package pid_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS      = 16;
  localparam int FIELD_W        = 32;
  localparam int REG_W          = 31;
  localparam int CFG_IDX_W      = 3;
  localparam int ERR_DIFF_W     = 34;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE      = 3'd5;

  localparam logic [REG_W-1:0] RST_GAIN           = 31'd0;
  localparam logic [REG_W-1:0] RST_INTEGRAL_LIMIT = 31'd6553600;
  localparam logic [REG_W-1:0] RST_STEP_TIME      = 31'd328;
  localparam logic [REG_W-1:0] RST_STEP_RATE      = 31'd13107200;

  // 180 and 360 degrees in Q16.16
  localparam logic signed [ERR_DIFF_W-1:0] ANGLE_HALF     = 34'sd11796480;
  localparam logic signed [ERR_DIFF_W-1:0] ANGLE_HALF_NEG = -34'sd11796480;
  localparam logic signed [ERR_DIFF_W-1:0] ANGLE_FULL     = 34'sd23592960;

  typedef struct packed {
    logic signed [FIELD_W-1:0] setpoint;
    logic signed [FIELD_W-1:0] measured_value;
    logic                      error_mode;
  } pid_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] drive;
    logic signed [FIELD_W-1:0] p_term;
    logic signed [FIELD_W-1:0] i_term;
    logic signed [FIELD_W-1:0] d_term;
  } pid_out_t;

endpackage

// ===== src/pid_step_with_integral_clamp.sv =====
// Single-channel PID step in signed Q16.16. Each request carries a setpoint, a measurement and
// an error mode (1 wraps the angle difference once into +/-180 degrees); the block returns the
// saturated sum of the P, I and D terms and each term alone, keeps the clamped integral and the
// previous error between requests, and takes its gains, integral limit, loop period and its
// reciprocal from six 31-bit registers written through the cfg port; the user must write them
// only while no request is in flight; the block does not enforce it. The block takes no new
// request until the current one is done. The five products run one after another
// through a single shared 32 x 31 multiplier that takes one 32-bit slice of the operand per
// cycle, out of NC = ceil((DATA_WIDTH + 1) / 32) slices. The result sits in an output
// register, so the next request is taken while it waits to be read.
module pid_step_with_integral_clamp #(
  parameter int DATA_WIDTH = pid_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pid_pkg::pid_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pid_pkg::pid_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [pid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pid_pkg::REG_W-1:0]      cfg_data_i
);

  localparam int DW    = DATA_WIDTH;
  localparam int MW    = DW + 1;
  localparam int CHUNK = 32;
  localparam int NC    = (MW + CHUNK - 1) / CHUNK;
  localparam int MAGW  = NC * CHUNK;
  localparam int AW    = MAGW + CHUNK;
  localparam int PW    = CHUNK + pid_pkg::REG_W;
  localparam int RW    = MW + pid_pkg::FRAC_BITS;
  localparam int XW    = (RW > 62) ? RW : 62;
  localparam int SW    = XW + 2;
  localparam int OW    = (DW > pid_pkg::FIELD_W) ? DW : pid_pkg::FIELD_W;
  localparam int CNTW  = $clog2(NC + 1);
  localparam int EW    = pid_pkg::ERR_DIFF_W;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [XW-1:0] TERM_HI = {{(XW-61){1'b0}}, 1'b1, {60{1'b0}}};
  localparam logic signed [XW-1:0] TERM_LO = -TERM_HI;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;

  localparam logic [2:0] PH_INT = 3'd0;
  localparam logic [2:0] PH_DER = 3'd1;
  localparam logic [2:0] PH_P   = 3'd2;
  localparam logic [2:0] PH_I   = 3'd3;
  localparam logic [2:0] PH_D   = 3'd4;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    if (x > SAT_HI) begin
      y = SAT_HI;
    end else if (x < SAT_LO) begin
      y = SAT_LO;
    end else begin
      y = x;
    end
    return y[DW-1:0];
  endfunction

  function automatic logic signed [XW-1:0] limit_term(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] y;
    if (x > TERM_HI) begin
      y = TERM_HI;
    end else if (x < TERM_LO) begin
      y = TERM_LO;
    end else begin
      y = x;
    end
    return y;
  endfunction

  function automatic logic [pid_pkg::FIELD_W-1:0] out32(input logic signed [DW-1:0] v);
    logic signed [OW-1:0] e;
    e = OW'(v);
    return e[pid_pkg::FIELD_W-1:0];
  endfunction

  // Control and state
  logic [2:0]              state_q, state_d;
  logic [2:0]              phase_q, phase_d;
  logic [CNTW-1:0]         cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [DW-1:0]    prev_q, prev_d;
  logic signed [DW-1:0]    integ_q, integ_d;
  logic [pid_pkg::REG_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [pid_pkg::REG_W-1:0] lim_q, step_time_q, step_rate_q;

  // Datapath
  pid_pkg::pid_in_t        in_q, in_d;
  pid_pkg::pid_out_t       out_q, out_d;
  logic signed [DW-1:0]    err_q, err_d;
  logic signed [DW-1:0]    deriv_q, deriv_d;
  logic signed [XW-1:0]    p_q, p_d, i_q, i_d, d_q, d_d;
  logic [MAGW-1:0]         mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic [pid_pkg::REG_W-1:0] mulb_q, mulb_d;
  logic signed [AW-1:0]    acc_q, acc_d;

  // Combinational helpers
  logic signed [EW-1:0]    diff, wrapped;
  logic signed [MW-1:0]    opa, opb, dif_ab, dif_ba;
  logic [pid_pkg::REG_W-1:0] op_gain;
  logic [MW-1:0]           op_mag;
  logic [CHUNK-1:0]        chunk;
  logic [PW-1:0]           prod;
  logic signed [AW-1:0]    prod_ext, acc_sh;
  logic signed [RW-1:0]    res;
  logic signed [RW:0]      isum, ilim_pos, ilim_neg, iclamp;
  logic signed [SW-1:0]    drive_sum;
  logic                    in_acc, out_acc, sum_go;

  assign in_acc  = in_valid_i && (state_q == S_IDLE);
  assign out_acc = out_valid_q && !out_stall_i;
  assign sum_go  = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Error with optional single angle wrap
  always_comb begin
    diff = EW'(in_q.setpoint) - EW'(in_q.measured_value);
    if (in_q.error_mode && (diff > pid_pkg::ANGLE_HALF)) begin
      wrapped = diff - pid_pkg::ANGLE_FULL;
    end else if (in_q.error_mode && (diff < pid_pkg::ANGLE_HALF_NEG)) begin
      wrapped = diff + pid_pkg::ANGLE_FULL;
    end else begin
      wrapped = diff;
    end
  end

  // Operand for the next product, as sign and magnitude
  always_comb begin
    opb = '0;
    unique case (phase_q)
      PH_INT: begin
        opa     = MW'(err_q);
        op_gain = step_time_q;
      end
      PH_DER: begin
        opa     = MW'(err_q);
        opb     = MW'(prev_q);
        op_gain = step_rate_q;
      end
      PH_P: begin
        opa     = MW'(err_q);
        op_gain = gain_p_q;
      end
      PH_I: begin
        opa     = MW'(integ_q);
        op_gain = gain_i_q;
      end
      default: begin
        opa     = MW'(deriv_q);
        op_gain = gain_d_q;
      end
    endcase
    dif_ab = opa - opb;
    dif_ba = opb - opa;
    op_mag = dif_ab[MW-1] ? dif_ba : dif_ab;
  end

  // Shared multiplier: one slice of the magnitude per cycle, most significant first
  assign chunk    = mag_q[MAGW-1 -: CHUNK];
  assign prod     = chunk * mulb_q;
  assign prod_ext = $signed({{(AW-PW){1'b0}}, prod});
  assign acc_sh   = acc_q <<< CHUNK;
  assign res      = acc_q[RW+pid_pkg::FRAC_BITS-1:pid_pkg::FRAC_BITS];

  // Integral accumulate and clamp
  always_comb begin
    isum     = (RW+1)'(res) + (RW+1)'(integ_q);
    ilim_pos = $signed({{(RW+1-pid_pkg::REG_W){1'b0}}, lim_q});
    ilim_neg = -ilim_pos;
    if (isum > ilim_pos) begin
      iclamp = ilim_pos;
    end else if (isum < ilim_neg) begin
      iclamp = ilim_neg;
    end else begin
      iclamp = isum;
    end
  end

  assign drive_sum = SW'(p_q) + SW'(i_q) + SW'(d_q);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    prev_d      = prev_q;
    integ_d     = integ_q;
    in_d        = in_q;
    out_d       = out_q;
    err_d       = err_q;
    deriv_d     = deriv_q;
    p_d         = p_q;
    i_d         = i_q;
    d_d         = d_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    mulb_d      = mulb_q;
    acc_d       = acc_q;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          in_d    = in_data_i;
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        err_d   = sat_dw(SW'(wrapped));
        phase_d = PH_INT;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        mag_d   = MAGW'(op_mag);
        neg_d   = dif_ab[MW-1];
        mulb_d  = op_gain;
        acc_d   = '0;
        cnt_d   = CNTW'(NC - 1);
        state_d = S_MUL;
      end
      S_MUL: begin
        acc_d = neg_q ? (acc_sh - prod_ext) : (acc_sh + prod_ext);
        mag_d = mag_q << CHUNK;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        state_d = S_LOAD;
        unique case (phase_q)
          PH_INT: begin
            integ_d = sat_dw(SW'(iclamp));
            phase_d = PH_DER;
          end
          PH_DER: begin
            deriv_d = sat_dw(SW'(res));
            phase_d = PH_P;
          end
          PH_P: begin
            p_d     = limit_term(XW'(res));
            phase_d = PH_I;
          end
          PH_I: begin
            i_d     = limit_term(XW'(res));
            phase_d = PH_D;
          end
          default: begin
            d_d     = limit_term(XW'(res));
            state_d = S_SUM;
          end
        endcase
      end
      S_SUM: begin
        // hold until the output register is free
        if (sum_go) begin
          out_d.drive  = out32(sat_dw(drive_sum));
          out_d.p_term = out32(sat_dw(SW'(p_q)));
          out_d.i_term = out32(sat_dw(SW'(i_q)));
          out_d.d_term = out32(sat_dw(SW'(d_q)));
          out_valid_d  = 1'b1;
          prev_d       = err_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_INT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      integ_q     <= '0;
      gain_p_q    <= pid_pkg::RST_GAIN;
      gain_i_q    <= pid_pkg::RST_GAIN;
      gain_d_q    <= pid_pkg::RST_GAIN;
      lim_q       <= pid_pkg::RST_INTEGRAL_LIMIT;
      step_time_q <= pid_pkg::RST_STEP_TIME;
      step_rate_q <= pid_pkg::RST_STEP_RATE;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
      integ_q     <= integ_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pid_pkg::REG_GAIN_P:         gain_p_q    <= cfg_data_i;
          pid_pkg::REG_GAIN_I:         gain_i_q    <= cfg_data_i;
          pid_pkg::REG_GAIN_D:         gain_d_q    <= cfg_data_i;
          pid_pkg::REG_INTEGRAL_LIMIT: lim_q       <= cfg_data_i;
          pid_pkg::REG_STEP_TIME:      step_time_q <= cfg_data_i;
          pid_pkg::REG_STEP_RATE:      step_rate_q <= cfg_data_i;
          default: begin
            // drop writes beyond the register map
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    out_q   <= out_d;
    err_q   <= err_d;
    deriv_q <= deriv_d;
    p_q     <= p_d;
    i_q     <= i_d;
    d_q     <= d_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    mulb_q  <= mulb_d;
    acc_q   <= acc_d;
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_ERR)
    else $error("accepted request did not start the error step");

  a_valid_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_SUM)
    else $error("result raised outside the sum step");

  a_sum_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SUM && out_valid_q && out_stall_i |=> state_q == S_SUM && out_valid_q)
    else $error("pending result overwritten");

  a_last_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POST && phase_q == PH_D |=> state_q == S_SUM)
    else $error("sequencer did not reach the sum step after the last product");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> cnt_q < CNTW'(NC))
    else $error("slice counter out of range");
`endif

endmodule
